/* sv/lcgsr_pkg.sv */
// Shared types and constants for the 48-bit LCG random source with stochastic rounding.
package lcgsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FRS_SHIFT = 48 - FRAC_BITS;

  localparam logic [47:0] LCG_MUL     = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD     = 48'h0000_0000_000B;
  localparam logic [15:0] SEED_LOW    = 16'h330E;
  localparam logic [47:0] STATE_RESET = 48'h0000_0000_330E;

  localparam logic [47:0] NEG_LIMIT = 48'h0000_8000_0000;
  localparam logic [47:0] POS_LIMIT = 48'h0000_7FFF_FFFF;
  localparam logic [31:0] NEG_SAT   = 32'h8000_0000;
  localparam logic [31:0] POS_SAT   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_ROUND  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_RESEED  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_HOLD    = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [31:0]  seed;
    logic signed [47:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [47:0]         random_fraction;
    logic signed [31:0]  rounded;
  } out_word_t;

  // decoded word between front and back
  typedef struct packed {
    op_t         op;
    logic [31:0] seed;
    logic        sat;
    logic [31:0] sat_val;
    logic [31:0] base;
    logic        neg;
    logic [47:0] frs;
  } op_word_t;

endpackage

/* sv/lcgsr_front.sv */
// Front end: decodes an input word and precomputes the rounding operands.
module lcgsr_front (
  input  lcgsr_pkg::in_word_t item,
  output lcgsr_pkg::op_word_t dec
);

  logic        neg;
  logic [47:0] mag;
  logic [47:0] ip;
  logic [47:0] lim;

  always_comb begin
    neg = item.value[47];
    mag = neg ? (~item.value + 48'd1) : item.value;
    ip  = mag >> lcgsr_pkg::FRAC_BITS;
    lim = neg ? lcgsr_pkg::NEG_LIMIT : lcgsr_pkg::POS_LIMIT;

    dec.seed    = item.seed;
    dec.sat     = 1'b1;
    dec.sat_val = '0;
    dec.base    = '0;
    dec.neg     = 1'b0;
    dec.frs     = '0;

    case (lcgsr_pkg::kind_t'(item.kind))
      lcgsr_pkg::KIND_RESEED: begin
        dec.op = lcgsr_pkg::OP_RESEED;
      end
      lcgsr_pkg::KIND_DRAW: begin
        dec.op = lcgsr_pkg::OP_ADVANCE;
      end
      lcgsr_pkg::KIND_ROUND: begin
        dec.op      = lcgsr_pkg::OP_ADVANCE;
        dec.sat     = (ip >= lim);
        dec.sat_val = neg ? lcgsr_pkg::NEG_SAT : lcgsr_pkg::POS_SAT;
        // -(ip + inc) = ~ip + (1 - inc)
        dec.base    = neg ? ~ip[31:0] : ip[31:0];
        dec.neg     = neg;
        dec.frs     = mag << lcgsr_pkg::FRS_SHIFT;
      end
      default: begin
        dec.op = lcgsr_pkg::OP_HOLD;
      end
    endcase
  end

endmodule

/* sv/lcgsr_opq.sv */
// Two-entry queue of decoded words between front and back.
module lcgsr_opq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcgsr_pkg::op_word_t wr_word,
  output logic                full,
  input  logic                pop,
  output lcgsr_pkg::op_word_t rd_word,
  output logic                empty
);

  lcgsr_pkg::op_word_t mem [2];
  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* sv/lcgsr_back.sv */
// Back end: LCG state update, stochastic rounding stage and result queue.
module lcgsr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcgsr_pkg::op_word_t  q_word,
  input  logic                 q_empty,
  output logic                 q_pop,
  output lcgsr_pkg::out_word_t result,
  output logic                 empty,
  input  logic                 pop
);

  logic [47:0] x;
  logic [47:0] x_next;

  logic        s1_valid;
  logic [47:0] s1_x;
  logic        s1_sat;
  logic [31:0] s1_sat_val;
  logic [31:0] s1_base;
  logic        s1_neg;
  logic [47:0] s1_frs;
  logic        s1_move;

  logic        inc;
  logic [31:0] rnd;
  lcgsr_pkg::out_word_t res_in;

  lcgsr_pkg::out_word_t mem [2];
  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_pop;

  assign empty   = (cnt == 2'd0);
  assign do_pop  = pop && !empty;
  assign s1_move = s1_valid && ((cnt != 2'd2) || do_pop);
  assign q_pop   = !q_empty && (!s1_valid || s1_move);
  assign result  = mem[rd_ptr];

  always_comb begin
    case (q_word.op)
      lcgsr_pkg::OP_RESEED:  x_next = {q_word.seed[15:0], q_word.seed[31:16],
                                       lcgsr_pkg::SEED_LOW};
      lcgsr_pkg::OP_ADVANCE: x_next = x * lcgsr_pkg::LCG_MUL + lcgsr_pkg::LCG_ADD;
      default:               x_next = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= lcgsr_pkg::STATE_RESET;
      s1_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        x        <= x_next;
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_x       <= x_next;
      s1_sat     <= q_word.sat;
      s1_sat_val <= q_word.sat_val;
      s1_base    <= q_word.base;
      s1_neg     <= q_word.neg;
      s1_frs     <= q_word.frs;
    end
  end

  always_comb begin
    inc = (s1_frs > s1_x);
    rnd = s1_sat ? s1_sat_val : (s1_base + {31'd0, inc ^ s1_neg});
    res_in.random_fraction = s1_x;
    res_in.rounded         = rnd;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      mem[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (s1_move) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({s1_move, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* sv/lcg48_random_with_stochastic_round_core.sv */
// Top level: 48-bit LCG random source with stochastic rounding.
//
//   channel  handshake     word
//   input    push / full   item   (kind, seed, value)
//   result   pop / empty   result (random_fraction, rounded)
//
// One word in and one word out per cycle, sustained while the result side pops every cycle.
// An accepted push passes the word queue, the s1 stage register and the result queue before empty goes low.
// The state recurrence (constant multiply-add mod 2^48) closes in one back-end stage.
// Synchronous reset loads the state with 0x330E and empties both queues.
// A stalled result side fills the result queue, then the word queue, then raises full.
module lcg48_random_with_stochastic_round_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcgsr_pkg::in_word_t  item,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output lcgsr_pkg::out_word_t result
);

  lcgsr_pkg::op_word_t dec;
  lcgsr_pkg::op_word_t q_word;
  logic                q_empty;
  logic                q_pop;

  lcgsr_front u_front (
    .item (item),
    .dec  (dec)
  );

  lcgsr_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (dec),
    .full    (full),
    .pop     (q_pop),
    .rd_word (q_word),
    .empty   (q_empty)
  );

  lcgsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_word  (q_word),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end took a word from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_empty)
    else $error("accepted word missing from queue");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the 48-bit LCG random core with stochastic rounding.

class lcg_result_book;
  lcgsr_pkg::out_word_t awaited[$];
  logic [47:0]          x_state;
  int unsigned          errors;

  function new();
    x_state = lcgsr_pkg::STATE_RESET;
    errors  = 0;
  endfunction

  function logic [47:0] lcg_next(logic [47:0] x);
    logic [47:0] n;
    n = lcgsr_pkg::LCG_MUL * x + lcgsr_pkg::LCG_ADD;
    return n;
  endfunction

  function logic [31:0] round_stoch(logic [47:0] v, logic [47:0] x);
    logic        neg;
    logic [48:0] mag;
    logic [48:0] ip;
    logic [47:0] frac_scaled;
    neg = v[47];
    mag = neg ? (49'h1_0000_0000_0000 - {1'b0, v}) : {1'b0, v};
    ip  = mag >> lcgsr_pkg::FRAC_BITS;
    frac_scaled = 48'(mag & ((49'd1 << lcgsr_pkg::FRAC_BITS) - 49'd1));
    frac_scaled = frac_scaled << lcgsr_pkg::FRS_SHIFT;
    // strict compare: no fraction never steps
    if (frac_scaled > x) ip = ip + 49'd1;
    if (!neg) return (ip > 49'(lcgsr_pkg::POS_LIMIT)) ? lcgsr_pkg::POS_SAT : ip[31:0];
    return (ip > 49'(lcgsr_pkg::NEG_LIMIT)) ? lcgsr_pkg::NEG_SAT : 32'(49'd0 - ip);
  endfunction

  function void note_item(lcgsr_pkg::in_word_t w);
    lcgsr_pkg::out_word_t e;
    e.rounded = '0;
    case (lcgsr_pkg::kind_t'(w.kind))
      lcgsr_pkg::KIND_RESEED: begin
        x_state = {w.seed[15:0], w.seed[31:16], lcgsr_pkg::SEED_LOW};
      end
      lcgsr_pkg::KIND_DRAW: begin
        x_state = lcg_next(x_state);
      end
      lcgsr_pkg::KIND_ROUND: begin
        x_state   = lcg_next(x_state);
        e.rounded = round_stoch(w.value, x_state);
      end
      default: ;
    endcase
    e.random_fraction = x_state;
    awaited.push_back(e);
  endfunction

  function void check_result(lcgsr_pkg::out_word_t r);
    lcgsr_pkg::out_word_t e;
    if (awaited.size() == 0) begin
      $error("unexpected word: random_fraction %h rounded %h", r.random_fraction, r.rounded);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (r.random_fraction !== e.random_fraction) begin
      $error("random_fraction: expected %h, actual %h", e.random_fraction, r.random_fraction);
      errors++;
    end
    if (r.rounded !== e.rounded) begin
      $error("rounded: expected %h, actual %h", e.rounded, r.rounded);
      errors++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM    = 1430;

  logic                 clk  = 1'b0;
  logic                 rst  = 1'b1;
  logic                 push = 1'b0;
  logic                 pop  = 1'b0;
  logic                 calm = 1'b0;
  lcgsr_pkg::in_word_t  item = '0;
  logic                 full;
  logic                 empty;
  lcgsr_pkg::out_word_t result;
  int unsigned          stall_cycles = 0;

  lcg_result_book book = new();

  always #6 clk = ~clk;

  lcg48_random_with_stochastic_round_core DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) book.check_result(result);
      if (push && !full) book.note_item(item);
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("lcg48_random_with_stochastic_round_core test failed");
    $finish;
  end

  function automatic lcgsr_pkg::in_word_t make_word(lcgsr_pkg::kind_t k, logic [31:0] s,
                                                    logic [47:0] v);
    lcgsr_pkg::in_word_t w;
    w.kind  = k;
    w.seed  = s;
    w.value = v;
    return w;
  endfunction

  function automatic lcgsr_pkg::kind_t rand_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return lcgsr_pkg::KIND_RESEED;
    if (r < 38) return lcgsr_pkg::KIND_DRAW;
    if (r < 93) return lcgsr_pkg::KIND_ROUND;
    return lcgsr_pkg::KIND_NONE;
  endfunction

  function automatic logic [47:0] rand_value();
    logic [47:0] mag;
    logic        neg;
    neg = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3: return 48'({$urandom(), $urandom()});
      4, 5: mag = 48'($urandom_range(0, 32'h000F_FFFF));
      6: return 48'({$urandom(), 16'h0000});
      7: return {16'h7FFF, 16'($urandom_range(16'hFFF0, 16'hFFFF)), 16'($urandom())};
      8: return {16'h8000, 16'($urandom_range(0, 15)), 16'($urandom())};
      default: mag = 48'($urandom_range(0, 16'hFFFF));
    endcase
    return neg ? (48'd0 - mag) : mag;
  endfunction

  task automatic send_word(input lcgsr_pkg::in_word_t w);
    while (!calm && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(make_word(lcgsr_pkg::KIND_DRAW,   $urandom(), rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_NONE,   $urandom(), rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h0000_0000_0000));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h7FFF_FFFF_FFFF));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h8000_0000_0000));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'hFFFF_FFFF_FFFF));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h0000_0001_0000));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'hFFFF_FFFD_0000));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h0000_0000_FFFF));
    send_word(make_word(lcgsr_pkg::KIND_RESEED, 32'h0000_0000, rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_DRAW,   $urandom(), rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_RESEED, 32'hFFFF_FFFF, rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h7FFF_FFFF_0001));
    send_word(make_word(lcgsr_pkg::KIND_RESEED, 32'h7FFF_FFFF, rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h8000_0000_0001));
    send_word(make_word(lcgsr_pkg::KIND_RESEED, 32'h8000_0000, rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h8000_0000_0001));
    send_word(make_word(lcgsr_pkg::KIND_NONE,   $urandom(), rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'h0000_0001_8000));
    send_word(make_word(lcgsr_pkg::KIND_RESEED, 32'h1234_ABCD, rand_value()));
    send_word(make_word(lcgsr_pkg::KIND_ROUND,  $urandom(), 48'hFFFF_FFFF_0000));
    send_word(make_word(lcgsr_pkg::KIND_DRAW,   $urandom(), rand_value()));

    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= 600 && i < 850);
      if (i == 400 || i == 1100) begin
        push <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_word(make_word(rand_kind(), $urandom(), rand_value()));
    end
    push <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("lcg48_random_with_stochastic_round_core test passed");
    end else begin
      $display("lcg48_random_with_stochastic_round_core test failed");
    end
    $finish;
  end
endmodule

/* lcg48_random_with_stochastic_round_core.f */
sv/lcgsr_pkg.sv
sv/lcgsr_front.sv
sv/lcgsr_opq.sv
sv/lcgsr_back.sv
sv/lcg48_random_with_stochastic_round_core.sv
verif/tb_top.sv
